// ===== rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

    // fixed field widths of the stream and configuration ports
    localparam int DATA_W = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 1;

    typedef enum logic [IDX_W-1:0] {
        CFG_KEY_EXPONENT = 1'b0,
        CFG_KEY_MODULUS  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_WAIT,
        ST_NEXT_BIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MOP_REDUCE,
        MOP_ACC,
        MOP_SQUARE
    } mul_op_t;

    typedef struct packed {
        logic    load_in;
        logic    mul_start;
        mul_op_t mul_op;
        logic    load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_special;
        logic mul_last;
        logic exp_lsb;
        logic exp_rest_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/mexp_ctrl.sv =====
`timescale 1ns / 1ps

module mexp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mexp_pkg::dp_status_t  status,
    output mexp_pkg::ctrl_cmd_t   cmd
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mexp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.load_in   = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.mul_op    = mexp_pkg::MOP_REDUCE;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            mexp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    // zero exponent or zero modulus need no arithmetic
                    if (status.in_special) begin
                        state_next = mexp_pkg::ST_FINISH;
                    end else begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_op    = mexp_pkg::MOP_REDUCE;
                        state_next    = mexp_pkg::ST_MUL_WAIT;
                    end
                end
            end
            mexp_pkg::ST_MUL_WAIT: begin
                if (status.mul_last) begin
                    state_next = mexp_pkg::ST_NEXT_BIT;
                end
            end
            mexp_pkg::ST_NEXT_BIT: begin
                // a set bit is cleared by the accumulator step, then revisited here
                priority if (status.exp_lsb) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = mexp_pkg::MOP_ACC;
                    state_next    = mexp_pkg::ST_MUL_WAIT;
                end else if (status.exp_rest_zero) begin
                    state_next = mexp_pkg::ST_FINISH;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = mexp_pkg::MOP_SQUARE;
                    state_next    = mexp_pkg::ST_MUL_WAIT;
                end
            end
            mexp_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = mexp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mexp_datapath.sv =====
`timescale 1ns / 1ps

module mexp_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [mexp_pkg::IDX_W-1:0]   cfg_index,
    input  logic [mexp_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [mexp_pkg::DATA_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mexp_pkg::DATA_W-1:0]  m_tdata,
    input  mexp_pkg::ctrl_cmd_t          cmd,
    output mexp_pkg::dp_status_t         status
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int EXT_W = WIDTH + 2;

    logic [WIDTH-1:0] base_w;
    logic [WIDTH-1:0] cfg_w;

    // port values to datapath width: truncate or zero-extend
    if (WIDTH > mexp_pkg::DATA_W) begin : g_in_ext
        assign base_w = {{(WIDTH - mexp_pkg::DATA_W){1'b0}}, s_tdata};
    end else begin : g_in_cut
        assign base_w = s_tdata[WIDTH-1:0];
    end

    if (WIDTH > mexp_pkg::CFG_W) begin : g_cfg_ext
        assign cfg_w = {{(WIDTH - mexp_pkg::CFG_W){1'b0}}, cfg_wdata};
    end else begin : g_cfg_cut
        assign cfg_w = cfg_wdata[WIDTH-1:0];
    end

    logic [WIDTH-1:0]           exp_key_reg, exp_key_next;
    logic [WIDTH-1:0]           mod_key_reg, mod_key_next;
    logic [WIDTH-1:0]           exp_reg, exp_next;
    logic [WIDTH-1:0]           sq_reg, sq_next;
    logic [WIDTH-1:0]           acc_reg, acc_next;
    logic [WIDTH-1:0]           mul_a_reg, mul_a_next;
    logic [WIDTH-1:0]           mul_b_reg, mul_b_next;
    logic [WIDTH-1:0]           mul_p_reg, mul_p_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    mexp_pkg::mul_op_t          op_reg, op_next;
    logic                       out_valid_reg, out_valid_next;
    logic [mexp_pkg::DATA_W-1:0] out_data_reg, out_data_next;

    logic             exp_zero;
    logic             mod_zero;
    logic             mod_one;
    logic             mul_last;
    logic [EXT_W-1:0] t_sum;
    logic [EXT_W-1:0] t_sub1;
    logic [EXT_W-1:0] t_sub2;
    logic [EXT_W-1:0] mod_ext;
    logic [EXT_W-1:0] mod_dbl;
    logic [WIDTH-1:0] step_p;
    logic [WIDTH-1:0] result_w;

    assign exp_zero = (exp_key_reg == '0);
    assign mod_zero = (mod_key_reg == '0);
    assign mod_one  = (mod_key_reg == WIDTH'(1));
    assign mul_last = busy_reg && (cnt_reg == CNT_W'(WIDTH - 1));

    // one double-and-add step: 2p + a*bit lies below 3m, so two trial subtracts suffice
    assign mod_ext = {2'b00, mod_key_reg};
    assign mod_dbl = {1'b0, mod_key_reg, 1'b0};
    assign t_sum   = {1'b0, mul_p_reg, 1'b0}
                   + (mul_b_reg[WIDTH-1] ? {2'b00, mul_a_reg} : '0);
    assign t_sub1  = t_sum - mod_ext;
    assign t_sub2  = t_sum - mod_dbl;

    always_comb begin
        priority if (t_sum >= mod_dbl) begin
            step_p = t_sub2[WIDTH-1:0];
        end else if (t_sum >= mod_ext) begin
            step_p = t_sub1[WIDTH-1:0];
        end else begin
            step_p = t_sum[WIDTH-1:0];
        end
    end

    // zero exponent gives 1 unreduced; zero modulus otherwise gives 0
    always_comb begin
        priority if (exp_zero) begin
            result_w = WIDTH'(1);
        end else if (mod_zero) begin
            result_w = '0;
        end else begin
            result_w = acc_reg;
        end
    end

    always_comb begin
        exp_key_next   = exp_key_reg;
        mod_key_next   = mod_key_reg;
        exp_next       = exp_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_p_next     = mul_p_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_wen) begin
            unique case (mexp_pkg::cfg_idx_t'(cfg_index))
                mexp_pkg::CFG_KEY_EXPONENT: exp_key_next = cfg_w;
                mexp_pkg::CFG_KEY_MODULUS:  mod_key_next = cfg_w;
                default: ;
            endcase
        end

        if (cmd.load_in) begin
            exp_next = exp_key_reg;
            acc_next = mod_one ? '0 : WIDTH'(1);
        end

        if (busy_reg) begin
            mul_p_next = step_p;
            mul_b_next = {mul_b_reg[WIDTH-2:0], 1'b0};
            cnt_next   = cnt_reg + CNT_W'(1);
            if (mul_last) begin
                busy_next = 1'b0;
                unique case (op_reg)
                    mexp_pkg::MOP_REDUCE: sq_next = step_p;
                    mexp_pkg::MOP_ACC: begin
                        acc_next = step_p;
                        exp_next = {exp_reg[WIDTH-1:1], 1'b0};
                    end
                    mexp_pkg::MOP_SQUARE: begin
                        sq_next  = step_p;
                        exp_next = {1'b0, exp_reg[WIDTH-1:1]};
                    end
                    default: ;
                endcase
            end
        end

        if (cmd.mul_start) begin
            busy_next  = 1'b1;
            op_next    = cmd.mul_op;
            mul_p_next = '0;
            cnt_next   = '0;
            unique case (cmd.mul_op)
                mexp_pkg::MOP_REDUCE: begin
                    // base mod m as 1 * base through the same unit
                    mul_a_next = WIDTH'(1);
                    mul_b_next = base_w;
                end
                mexp_pkg::MOP_ACC: begin
                    mul_a_next = acc_reg;
                    mul_b_next = sq_reg;
                end
                mexp_pkg::MOP_SQUARE: begin
                    mul_a_next = sq_reg;
                    mul_b_next = sq_reg;
                end
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = mexp_pkg::DATA_W'(result_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_key_reg   <= '0;
            mod_key_reg   <= WIDTH'(1);
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            op_reg        <= mexp_pkg::MOP_REDUCE;
            out_valid_reg <= 1'b0;
        end else begin
            exp_key_reg   <= exp_key_next;
            mod_key_reg   <= mod_key_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg      <= exp_next;
        sq_reg       <= sq_next;
        acc_reg      <= acc_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        mul_p_reg    <= mul_p_next;
        out_data_reg <= out_data_next;
    end

    assign status.in_special    = exp_zero || mod_zero;
    assign status.mul_last      = mul_last;
    assign status.exp_lsb       = exp_reg[0];
    assign status.exp_rest_zero = (exp_reg[WIDTH-1:1] == '0);
    assign status.out_free      = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// base^exponent mod modulus, right-to-left square-and-multiply, one base at a time
// the base is first reduced mod modulus, then each modular multiply is a bit-serial
// double-and-add: a set bit costs one multiply, each bit below the top one also a square
// zero exponent or zero modulus skip the arithmetic and go straight to the finish;
// next base taken in the cycle after the result is loaded, a waiting result blocks the finish
// reset: synchronous active low, exponent 0, modulus 1, no result pending
module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [mexp_pkg::IDX_W-1:0]   cfg_index,
    input  logic [mexp_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mexp_pkg::DATA_W-1:0]  s_tdata,   // [31:0] base_value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mexp_pkg::DATA_W-1:0]  m_tdata    // [31:0] power_result
);

    mexp_pkg::ctrl_cmd_t  cmd;
    mexp_pkg::dp_status_t status;

    mexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mexp_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sim/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RUN_PHASES  = 9;
    localparam int PHASE_ITEMS = 30;

    // keeps the key as the block sees it and the powers still to come out
    class power_board;
        logic [31:0] exponent = 32'd0;
        logic [31:0] modulus  = 32'd1;
        logic [31:0] pending_powers[$];
        int          errors   = 0;

        function void set_key(mexp_pkg::cfg_idx_t idx, logic [31:0] value);
            if (idx == mexp_pkg::CFG_KEY_EXPONENT) begin
                exponent = value;
            end else begin
                modulus = value;
            end
        endfunction

        function logic [31:0] mod_power(logic [31:0] base);
            longint unsigned m;
            longint unsigned acc;
            longint unsigned sq;
            logic [31:0]     e;
            // zero exponent gives 1 unreduced, even for a modulus of one or zero
            if (exponent == 32'd0)
                return 32'd1;
            if (modulus == 32'd0)
                return 32'd0;
            m   = 64'(modulus);
            sq  = 64'(base) % m;
            acc = 64'd1 % m;
            e   = exponent;
            while (e != 32'd0) begin
                if (e[0])
                    acc = (acc * sq) % m;
                sq = (sq * sq) % m;
                e  = e >> 1;
            end
            return acc[31:0];
        endfunction

        function void note_base(logic [31:0] base);
            pending_powers.push_back(mod_power(base));
        endfunction

        function int outstanding();
            return pending_powers.size();
        endfunction

        task report_mismatch(string msg);
            $display("%s", msg);
            errors++;
        endtask

        task check_power(logic [31:0] got);
            logic [31:0] want;
            if (pending_powers.size() == 0) begin
                report_mismatch($sformatf("unexpected power_result %h", got));
            end else begin
                want = pending_powers.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("power_result %h, wanted %h (e=%h m=%h)",
                                              got, want, exponent, modulus));
            end
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wen;
    logic [mexp_pkg::IDX_W-1:0]     cfg_index;
    logic [mexp_pkg::CFG_W-1:0]     cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [mexp_pkg::DATA_W-1:0]    s_tdata;    // [31:0] base_value
    logic                           m_tvalid;
    logic                           m_tready;
    logic [mexp_pkg::DATA_W-1:0]    m_tdata;    // [31:0] power_result

    power_board board = new();
    bit         calm  = 1'b0;
    int         cycles = 0;

    modular_exponentiation #(.WIDTH(32)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: check each transaction, then maybe stall for the next edge
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_power(m_tdata);
            m_tready <= calm || ($urandom_range(99) >= 28);
        end
    end

    task automatic send_base(input logic [31:0] base);
        while (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= base;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_base(base);
    endtask

    task automatic drain_powers();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.outstanding() != 0)
            @(posedge aclk);
    endtask

    // only called with nothing in flight; the caller drops the write enable
    task automatic write_key(input mexp_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_key(idx, value);
    endtask

    task automatic load_key(input logic [31:0] e, input logic [31:0] m);
        drain_powers();
        write_key(mexp_pkg::CFG_KEY_EXPONENT, e);
        write_key(mexp_pkg::CFG_KEY_MODULUS, m);
        cfg_wen <= 1'b0;
    endtask

    function automatic logic [31:0] pick_base(logic [31:0] m);
        case ($urandom_range(0, 5))
            0: return 32'(m - $urandom_range(0, 3));
            1: return 32'($urandom_range(0, 15));
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            3: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_modulus();
        logic [31:0] m;
        m = $urandom;
        if (m == 32'd0)
            m = 32'd1;
        return m;
    endfunction

    initial begin
        logic [31:0] e;
        logic [31:0] m;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = mexp_pkg::CFG_KEY_EXPONENT;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // key left at reset: zero exponent, modulus one
        send_base(32'd0);
        send_base(32'hFFFF_FFFF);

        load_key(32'd1, 32'hFFFF_FFFF);
        send_base(32'd0);
        send_base(32'd1);
        send_base(32'hFFFF_FFFE);
        send_base(32'hFFFF_FFFF);
        send_base(32'h1234_5678);

        // full exponent against the largest 32-bit prime
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFB);
        send_base(32'd2);
        send_base(32'd3);
        send_base(32'hFFFF_FFFF);

        load_key(32'd2, 32'd1);
        send_base(32'd5);
        send_base(32'hFFFF_FFFF);

        // zero modulus: nothing to reduce by
        load_key(32'd5, 32'd0);
        send_base(32'd7);
        send_base(32'd0);
        load_key(32'd0, 32'd0);
        send_base(32'd9);

        // small textbook key
        load_key(32'd65537, 32'd3233);
        send_base(32'd65);
        send_base(32'd123);

        load_key(32'h8000_0000, 32'h8000_0000);
        send_base(32'hFFFF_FFFF);
        send_base(32'hAAAA_AAAA);
        send_base(32'd3);

        for (int phase = 0; phase < RUN_PHASES; phase++) begin
            m = pick_modulus();
            case (phase)
                0: e = $urandom_range(1, 255);
                1: begin
                    e = $urandom_range(1, 65535);
                    m = $urandom_range(2, 1000);
                end
                2: begin
                    e = $urandom;
                    m = m | 32'h8000_0000;
                end
                3: e = 32'd0;
                4: begin
                    e = $urandom_range(1, 255);
                    m = 32'hFFFF_FFFF;
                end
                5: begin
                    e = $urandom_range(1, 255);
                    m = 32'd1;
                end
                6: begin
                    e = 32'hFFFF_FFFF;
                    m = m | 32'd1;
                end
                7: begin
                    e = $urandom_range(1, 4095);
                    m = 32'd0;
                end
                default: e = $urandom_range(1, 1023);
            endcase
            load_key(e, m);
            calm = (phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off the sender until the block has emptied out
                if (phase == 8 && n == PHASE_ITEMS / 2)
                    drain_powers();
                send_base(pick_base(m));
            end
        end
        calm = 1'b0;

        drain_powers();
        repeat (40) @(posedge aclk);
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
